FILE: src/radar_data_level_decoder_assert.svh
// ----------------------------------------------------------------------------
// radar data level decoder assertion macros
// concurrent checks on the clock and reset of the including module
// ----------------------------------------------------------------------------
`ifndef RADAR_DATA_LEVEL_DECODER_ASSERT_SVH
`define RADAR_DATA_LEVEL_DECODER_ASSERT_SVH
`ifndef SYNTH
`define RDLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RDLD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDLD_ASSERT(lbl, prop, msg)
`define RDLD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: src/rdld_pkg.sv
// ----------------------------------------------------------------------------
// rdld_pkg
// shared types, constants and product rule functions of the level decoder
// ----------------------------------------------------------------------------
package rdld_pkg;

  localparam int TABLE_WORDS = 16;
  localparam int IDX_W = $clog2(TABLE_WORDS);

  typedef enum logic [5:0] {
    CODE_BLANK, CODE_BELOW_THRESHOLD, CODE_NO_DATA, CODE_RANGE_FOLDED,
    CODE_BIOLOGICAL, CODE_AP_CLUTTER, CODE_ICE_CRYSTALS, CODE_GRAUPEL,
    CODE_WET_SNOW, CODE_DRY_SNOW, CODE_LIGHT_RAIN, CODE_HEAVY_RAIN,
    CODE_BIG_DROPS, CODE_SMALL_HAIL, CODE_UNKNOWN_CLASS, CODE_LARGE_HAIL,
    CODE_GIANT_HAIL, CODE_NO_ACCUM, CODE_OUTSIDE_COVERAGE, CODE_FLAGGED,
    CODE_RESERVED, CODE_BAD_DATA, CODE_EDIT_REMOVE, CODE_CHAFF,
    CODE_NO_PRECIP, CODE_UNFILLED, CODE_CONVECTIVE, CODE_TROPICAL,
    CODE_SPEC_ATTEN, CODE_KL, CODE_KH, CODE_Z1, CODE_Z6, CODE_Z8, CODE_SI
  } code_t;

  typedef struct packed {
    logic  valid;
    code_t code;
  } code_res_t;

  function automatic logic in_linear(input logic signed [9:0] p);
    unique case (p)
      10'sd32, 10'sd93, 10'sd94, 10'sd99, 10'sd153, 10'sd154, 10'sd155,
      10'sd180, 10'sd182, 10'sd186, 10'sd193, 10'sd195: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic in_float(input logic signed [9:0] p);
    unique case (p)
      10'sd159, 10'sd161, 10'sd163, 10'sd167, 10'sd168, 10'sd170,
      10'sd172, 10'sd173, 10'sd174, 10'sd175, 10'sd176: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_uncoded(input logic signed [9:0] p);
    unique case (p)
      10'sd32, 10'sd34, 10'sd81, 10'sd93, 10'sd94, 10'sd99, 10'sd134,
      10'sd135, 10'sd138, 10'sd153, 10'sd154, 10'sd155, 10'sd159, 10'sd161,
      10'sd163, 10'sd177, 10'sd193, 10'sd195: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic code_res_t hydro_code(input logic [7:0] lv);
    code_res_t r;
    r.valid = 1'b1;
    unique case (lv)
      8'd0:    r.code = CODE_BELOW_THRESHOLD;
      8'd10:   r.code = CODE_BIOLOGICAL;
      8'd20:   r.code = CODE_AP_CLUTTER;
      8'd30:   r.code = CODE_ICE_CRYSTALS;
      8'd40:   r.code = CODE_DRY_SNOW;
      8'd50:   r.code = CODE_WET_SNOW;
      8'd60:   r.code = CODE_LIGHT_RAIN;
      8'd70:   r.code = CODE_HEAVY_RAIN;
      8'd80:   r.code = CODE_BIG_DROPS;
      8'd90:   r.code = CODE_GRAUPEL;
      8'd100:  r.code = CODE_SMALL_HAIL;
      8'd110:  r.code = CODE_LARGE_HAIL;
      8'd120:  r.code = CODE_GIANT_HAIL;
      8'd140:  r.code = CODE_UNKNOWN_CLASS;
      8'd150:  r.code = CODE_RANGE_FOLDED;
      default: begin
        r.valid = 1'b0;
        r.code  = CODE_BLANK;
      end
    endcase
    return r;
  endfunction

  function automatic code_res_t accum_code(input logic [7:0] lv);
    code_res_t r;
    r.valid = 1'b1;
    unique case (lv)
      8'd0:    r.code = CODE_NO_PRECIP;
      8'd10:   r.code = CODE_UNFILLED;
      8'd20:   r.code = CODE_CONVECTIVE;
      8'd30:   r.code = CODE_TROPICAL;
      8'd40:   r.code = CODE_SPEC_ATTEN;
      8'd50:   r.code = CODE_KL;
      8'd60:   r.code = CODE_KH;
      8'd70:   r.code = CODE_Z1;
      8'd80:   r.code = CODE_Z6;
      8'd90:   r.code = CODE_Z8;
      8'd100:  r.code = CODE_SI;
      default: begin
        r.valid = 1'b0;
        r.code  = CODE_BLANK;
      end
    endcase
    return r;
  endfunction

  function automatic code_res_t special_code_for(input logic signed [9:0] p,
                                                 input logic [7:0] lv);
    code_res_t r;
    r.valid = 1'b0;
    r.code  = CODE_BLANK;
    unique case (p)
      10'sd32, 10'sd93, 10'sd94, 10'sd99, 10'sd153, 10'sd154, 10'sd155,
      10'sd159, 10'sd161, 10'sd163, 10'sd167, 10'sd168, 10'sd195: begin
        if (lv == 8'd0) r = '{1'b1, CODE_BELOW_THRESHOLD};
        else if (lv == 8'd1) r = '{1'b1, CODE_RANGE_FOLDED};
      end
      10'sd81: begin
        if (lv == 8'd0) r = '{1'b1, CODE_NO_ACCUM};
        else if (lv == 8'd255) r = '{1'b1, CODE_OUTSIDE_COVERAGE};
      end
      10'sd134: begin
        if (lv == 8'd0) r = '{1'b1, CODE_BELOW_THRESHOLD};
        else if (lv == 8'd1) r = '{1'b1, CODE_FLAGGED};
        else if (lv == 8'd255) r = '{1'b1, CODE_RESERVED};
      end
      10'sd135: begin
        if (lv == 8'd0) r = '{1'b1, CODE_BELOW_THRESHOLD};
        else if (lv == 8'd1) r = '{1'b1, CODE_BAD_DATA};
      end
      10'sd138: begin
        if (lv == 8'd0) r = '{1'b1, CODE_NO_ACCUM};
      end
      10'sd165, 10'sd177: r = hydro_code(lv);
      10'sd170, 10'sd172, 10'sd173, 10'sd174, 10'sd175: begin
        if (lv == 8'd0) r = '{1'b1, CODE_NO_DATA};
      end
      10'sd193: begin
        if (lv == 8'd0) r = '{1'b1, CODE_BELOW_THRESHOLD};
        else if (lv == 8'd1) r = '{1'b1, CODE_RANGE_FOLDED};
        else if (lv == 8'd2) r = '{1'b1, CODE_EDIT_REMOVE};
        else if (lv == 8'd254) r = '{1'b1, CODE_CHAFF};
      end
      10'sd197: r = accum_code(lv);
      default: r = r;
    endcase
    return r;
  endfunction

  // scale per level of a threshold word, by its divider flags
  function automatic logic [16:0] thr_step(input logic [2:0] flags);
    logic [16:0] s;
    case (flags)
      3'b000:  s = 17'd100000;
      3'b001:  s = 17'd10000;
      3'b010:  s = 17'd5000;
      3'b011:  s = 17'd500;
      3'b100:  s = 17'd1000;
      3'b101:  s = 17'd100;
      3'b110:  s = 17'd50;
      default: s = 17'd5;
    endcase
    return s;
  endfunction

endpackage

FILE: src/radar_data_level_decoder.sv
// ----------------------------------------------------------------------------
// radar data level decoder
// Input channel s_*: s_tuser[0] 0 loads header word s_tdata[19:4] at table
// position s_tdata[3:0]; 1 decodes level s_tdata[27:20]. Loads give no
// result. Each decode gives one transfer on m_* holding has_value, value
// (1e-5 units), has_code, code and the unsupported flag.
// cfg_wr_en/cfg_wr_data write the signed product code; the user must do so
// only while idle (not enforced). The result is valid the cycle after the input
// transfer; one item is taken every cycle, set by the single result register.
// s_tready stays high while the result register is empty or being emptied, so
// a stalled receiver holds one result and the input stalls behind it.
// Reset (rst, synchronous) clears the header table, the product code and
// the result valid.
// ----------------------------------------------------------------------------
`include "radar_data_level_decoder_assert.svh"

module radar_data_level_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // word_index, word_value, level, zero fill
  input  logic [0:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // has_value, value, has_code, code, unsupported
);

  logic [15:0]                  hdr [rdld_pkg::TABLE_WORDS];
  logic signed [9:0]            prod_sel;
  logic                         s_acc;
  logic [rdld_pkg::IDX_W-1:0]   word_index;
  logic [15:0]                  word_value;
  logic [7:0]                   lv;
  logic                         lin, flt, coded;
  logic [15:0]                  thr, nlev, th;
  logic [23:0]                  prod;
  logic signed [43:0]           scaled, offs, lin_val, thr_val, val;
  logic [24:0]                  thr_mag;
  logic                         has_value, unsup, lv_low;
  rdld_pkg::code_res_t          cr;

  assign s_tready   = !m_tvalid || m_tready;
  assign s_acc      = s_tvalid && s_tready;
  assign word_index = s_tdata[3:0];
  assign word_value = s_tdata[19:4];
  assign lv         = s_tdata[27:20];

  always_comb begin
    lin    = rdld_pkg::in_linear(prod_sel);
    flt    = rdld_pkg::in_float(prod_sel);
    lv_low = (lv[7:4] == 4'd0);
    th     = hdr[lv[3:0]];

    if (lin && prod_sel != 10'sd155 && prod_sel != 10'sd193) thr = 16'd2;
    else if (flt) thr = hdr[6];
    else if (prod_sel == 10'sd135) thr = 16'd2;
    else if (prod_sel == 10'sd138) thr = hdr[0];
    else if (prod_sel == 10'sd155) thr = 16'd129;
    else if (prod_sel == 10'sd193) thr = 16'd3;
    else if (prod_sel == 10'sd165 || prod_sel == 10'sd177) thr = 16'd10;
    else thr = 16'd1;

    if (lin || prod_sel == 10'sd81 || prod_sel == 10'sd138) nlev = hdr[2];
    else if (flt) nlev = hdr[5];
    else begin
      unique case (prod_sel)
        10'sd30, 10'sd65, 10'sd66, 10'sd67, 10'sd84, 10'sd86, 10'sd90: nlev = 16'd8;
        10'sd113: nlev = 16'd13;
        10'sd132: nlev = 16'd11;
        10'sd133: nlev = 16'd12;
        10'sd134: nlev = 16'd256;
        10'sd135: nlev = 16'd200;
        10'sd165, 10'sd177: nlev = 16'd160;
        10'sd178, 10'sd179: nlev = 16'd71;
        default: nlev = 16'd16;
      endcase
    end
    coded = (nlev <= 16'd16) && !rdld_pkg::is_uncoded(prod_sel);

    // linear path
    prod = {16'd0, lv} * {8'd0, hdr[1]};
    if (lin) begin
      scaled = 44'(prod) * 44'sd10000;
      offs   = 44'($signed(hdr[0])) * 44'sd10000;
    end else if (prod_sel == 10'sd81) begin
      scaled = 44'(prod) * 44'sd100;
      offs   = 44'($signed(hdr[0])) * 44'sd10000;
    end else if (prod_sel == 10'sd135) begin
      scaled = 44'(prod) * 44'sd100000;
      offs   = 44'($signed(hdr[2])) * 44'sd100000;
    end else if (prod_sel == 10'sd138) begin
      scaled = 44'(prod) * 44'sd1000;
      offs   = '0;
    end else begin
      scaled = 44'(lv) * 44'sd100000;
      offs   = '0;
    end
    lin_val = scaled + offs;

    // threshold word path
    thr_mag = th[7:0] * (th[15] ? 17'd100000 : rdld_pkg::thr_step(th[14:12]));
    thr_val = (!th[15] && th[8]) ? -44'(thr_mag) : 44'(thr_mag);

    has_value = 1'b0;
    unsup     = 1'b0;
    val       = '0;
    if ({8'd0, lv} >= thr) begin
      if (!coded) begin
        if (prod_sel == 10'sd134 || flt) unsup = 1'b1;
        else begin
          has_value = 1'b1;
          val       = lin_val;
        end
      end else if (lv_low) begin
        has_value = 1'b1;
        val       = thr_val;
      end
    end

    cr = rdld_pkg::special_code_for(prod_sel, lv);
    if (!cr.valid && coded && lv_low && th[15] && th[7:0] <= 8'd16) begin
      cr.valid = 1'b1;
      cr.code  = rdld_pkg::code_t'(th[5:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_sel <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < rdld_pkg::TABLE_WORDS; i++) hdr[i] <= '0;
    end else begin
      if (cfg_wr_en) prod_sel <= $signed(cfg_wr_data);
      if (s_acc && !s_tuser[0]) hdr[word_index] <= word_value;
      if (s_acc && s_tuser[0]) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (s_acc && s_tuser[0]) begin
      m_tdata <= {3'b000, unsup, cr.valid ? cr.code : rdld_pkg::CODE_BLANK, cr.valid,
                  val, has_value};
    end
  end

  `RDLD_ASSERT(a_decode_gives_result, s_acc && s_tuser[0] |=> m_tvalid,
    "decode transfer gave no result")
  `RDLD_ASSERT(a_load_gives_none, s_acc && !s_tuser[0] && !m_tvalid |=> !m_tvalid,
    "load transfer gave a result")
  `RDLD_ASSERT(a_value_or_unsup, m_tvalid |-> !(m_tdata[0] && m_tdata[52]),
    "value and unsupported both set")
  `RDLD_ASSERT_RST(a_reset_clears, rst |=> !m_tvalid, "result valid after reset")

endmodule
